/* hdl/cqdep_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqdep_pkg
// Shared types and constants for the double-ended-pop circular queue.
// ----------------------------------------------------------------------------
package cqdep_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 7;
  localparam int CMD_W     = 3;
  localparam int ST_W      = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ        = 3'd0,
    CMD_DEQ_FRONT  = 3'd1,
    CMD_DEQ_REAR   = 3'd2,
    CMD_PEEK_FRONT = 3'd3,
    CMD_PEEK_REAR  = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_NEG1 = 2'd1,
    SRC_MEM  = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

endpackage

/* hdl/cqdep_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqdep_ctrl
// Command sequencer: accept, execute against the slot memory, present result.
// ----------------------------------------------------------------------------
module cqdep_ctrl
  import cqdep_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output ctl_cmd_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE, S_DONE: begin
        state_next = start ? S_EXEC : S_IDLE;
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    done     = 1'b0;
    ctl.load = 1'b0;
    ctl.exec = 1'b0;
    unique case (state)
      S_IDLE: begin
        ctl.load = start;
      end
      S_EXEC: begin
        busy     = 1'b1;
        ctl.exec = 1'b1;
      end
      S_DONE: begin
        done     = 1'b1;
        ctl.load = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/cqdep_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqdep_dp
// Queue datapath: slot memory, head/tail pointers, fill count, capacity.
// ----------------------------------------------------------------------------
module cqdep_dp
  import cqdep_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_cmd_t                 ctl,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  output logic signed [DATA_W-1:0] data,
  output logic [ST_W-1:0]          status,
  output logic [CAP_W-1:0]         count
);

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CMP_W     = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
  localparam int DEPTH_CAP = (DEPTH < 127) ? DEPTH : 127;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] value_q;
  logic [CAP_W-1:0]  capacity;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  tail_next;
  logic [CAP_W-1:0]  fill;
  logic [CAP_W-1:0]  fill_next;
  logic [DATA_W-1:0] rd_data;
  src_t              src_q;
  src_t              src_d;
  status_t           status_q;
  status_t           status_d;
  logic [CAP_W-1:0]  count_q;

  logic [CAP_W-1:0]  eff_cap;
  logic [CMP_W-1:0]  head_inc;
  logic [CMP_W-1:0]  tail_inc;
  logic [PTR_W-1:0]  head_adv;
  logic [PTR_W-1:0]  tail_adv;
  logic [PTR_W-1:0]  tail_back;
  logic [PTR_W-1:0]  rd_addr;
  logic              empty;
  logic              full;
  logic              mem_we;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (capacity > CAP_W'(DEPTH_CAP)) begin
      eff_cap = CAP_W'(DEPTH_CAP);
    end else begin
      eff_cap = capacity;
    end
  end

  assign empty     = (fill == '0);
  assign full      = (fill >= eff_cap);
  assign head_inc  = CMP_W'(head) + CMP_W'(1);
  assign tail_inc  = CMP_W'(tail) + CMP_W'(1);
  assign head_adv  = (head_inc >= CMP_W'(eff_cap)) ? '0 : PTR_W'(head_inc);
  assign tail_adv  = (tail_inc >= CMP_W'(eff_cap)) ? '0 : PTR_W'(tail_inc);
  assign tail_back = (tail == '0) ? PTR_W'(eff_cap - CAP_W'(1)) : tail - PTR_W'(1);
  assign rd_addr   = (cmd_q == CMD_DEQ_FRONT || cmd_q == CMD_PEEK_FRONT) ? head : tail_back;
  assign mem_we    = ctl.exec && (cmd_q == CMD_ENQ) && !full;

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    src_d     = SRC_ZERO;
    status_d  = ST_OK;
    unique case (cmd_q)
      CMD_ENQ: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          tail_next = tail_adv;
          fill_next = fill + CAP_W'(1);
        end
      end
      CMD_DEQ_FRONT: begin
        if (empty) begin
          src_d    = SRC_NEG1;
          status_d = ST_EMPTY;
        end else begin
          src_d     = SRC_MEM;
          head_next = head_adv;
          fill_next = fill - CAP_W'(1);
        end
      end
      CMD_DEQ_REAR: begin
        if (empty) begin
          src_d    = SRC_NEG1;
          status_d = ST_EMPTY;
        end else begin
          src_d     = SRC_MEM;
          tail_next = tail_back;
          fill_next = fill - CAP_W'(1);
        end
      end
      CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          src_d = SRC_MEM;
        end
      end
      CMD_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        fill_next = '0;
      end
      default: begin
        src_d = SRC_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= value_q;
    end
    if (ctl.exec) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= command;
      value_q <= value;
    end
    if (ctl.exec) begin
      src_q    <= src_d;
      status_q <= status_d;
      count_q  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (ctl.exec) begin
        head <= head_next;
        tail <= tail_next;
        fill <= fill_next;
      end
    end
  end

  always_comb begin
    case (src_q)
      SRC_MEM:  data = rd_data;
      SRC_NEG1: data = '1;
      default:  data = '0;
    endcase
  end

  assign status = status_q;
  assign count  = count_q;

endmodule

/* hdl/circular_queue_double_ended_pop.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_double_ended_pop
// Ring-buffer queue of signed 32-bit words, pop from either end.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Each command passes
// through an access state, which accesses the slot memory and updates the
// pointers, and then a done state, in which the result (data, status, count)
// is shown with done high for exactly that cycle. The memory read is
// registered. busy is high only in the access state, so the next command may
// be issued in the cycle done is shown. The receiver cannot stall: a result
// must be captured in its done cycle. Capacity must be written with cfg_we
// only while no command is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module circular_queue_double_ended_pop
  import cqdep_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  output logic                     done,
  output logic signed [DATA_W-1:0] data,
  output logic [ST_W-1:0]          status,
  output logic [CAP_W-1:0]         count
);

  ctl_cmd_t ctl;

  cqdep_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  cqdep_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .command   (command),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .data      (data),
    .status    (status),
    .count     (count)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not enter execution");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("execution not followed by a result");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (count == '0))
    else $error("empty status with nonzero count");

  a_full_data: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (data == '0 && count != '0))
    else $error("full status with bad data or count");

endmodule

/* verif/circular_queue_double_ended_pop_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_double_ended_pop_tb
// Self-checking bench for the double-ended-pop circular queue.
// ----------------------------------------------------------------------------
// Commands go in on the start/busy handshake. Each accepted beat is run
// through a queue predictor that keeps its own slots, pointers, count and
// capacity. Every done beat is checked field by field against the oldest
// predicted reply. A directed pass covers empty, full and extreme words,
// every command, odd capacities and capacity changes with words stored.
// Random phases follow with a fresh capacity each, under three idle
// regimes on the command side.
// ----------------------------------------------------------------------------
module circular_queue_double_ended_pop_tb;
  import cqdep_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;
  localparam int BEATS_PER_REGIME = 283;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0]          status;
    logic [CAP_W-1:0]         count;
  } queue_reply_t;

  class queue_scoreboard;
    logic [DATA_W-1:0] slots [DEPTH_DEF];
    bit                written [DEPTH_DEF];
    int                head;
    int                tail;
    int                fill;
    logic [CAP_W-1:0]  capacity;
    queue_reply_t      replies_q [$];
    int                errors;

    function new();
      head = 0;
      tail = 0;
      fill = 0;
      capacity = CAP_RESET;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function int eff_cap();
      if (capacity == 0) return 1;
      if (capacity > DEPTH_DEF) return DEPTH_DEF;
      return int'(capacity);
    endfunction

    function int step_fwd(int p, int c);
      return (p + 1 >= c) ? 0 : p + 1;
    endfunction

    function int step_back(int p, int c);
      return (p == 0) ? c - 1 : p - 1;
    endfunction

    // never read a slot that was not written
    function bit readable(logic [CMD_W-1:0] cmd);
      if (fill == 0) return 1'b1;
      case (cmd)
        CMD_DEQ_FRONT, CMD_PEEK_FRONT: return written[head];
        CMD_DEQ_REAR, CMD_PEEK_REAR: return written[step_back(tail, eff_cap())];
        default: return 1'b1;
      endcase
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
      queue_reply_t r;
      int c;
      int p;
      c = eff_cap();
      r.data = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_ENQ: begin
          if (fill >= c) begin
            r.status = ST_FULL;
          end else begin
            slots[tail] = val;
            written[tail] = 1'b1;
            tail = step_fwd(tail, c);
            fill++;
          end
        end
        CMD_DEQ_FRONT: begin
          if (fill == 0) begin
            r.data = -1;
            r.status = ST_EMPTY;
          end else begin
            r.data = slots[head];
            head = step_fwd(head, c);
            fill--;
          end
        end
        CMD_DEQ_REAR: begin
          if (fill == 0) begin
            r.data = -1;
            r.status = ST_EMPTY;
          end else begin
            p = step_back(tail, c);
            r.data = slots[p];
            tail = p;
            fill--;
          end
        end
        CMD_PEEK_FRONT: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.data = slots[head];
        end
        CMD_PEEK_REAR: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.data = slots[step_back(tail, c)];
        end
        CMD_CLEAR: begin
          head = 0;
          tail = 0;
          fill = 0;
        end
        default: ;
      endcase
      r.count = CAP_W'(fill);
      replies_q.push_back(r);
    endfunction

    function void check_reply(logic [DATA_W-1:0] d, logic [ST_W-1:0] s,
                              logic [CAP_W-1:0] n);
      queue_reply_t want;
      if (replies_q.size() == 0) begin
        $display("%0t: unexpected beat data %0d status %0d count %0d",
                 $time, $signed(d), s, n);
        errors++;
        return;
      end
      want = replies_q.pop_front();
      if (d !== want.data) begin
        $display("%0t: data expected %0d got %0d", $time, want.data, $signed(d));
        errors++;
      end
      if (s !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, s);
        errors++;
      end
      if (n !== want.count) begin
        $display("%0t: count expected %0d got %0d", $time, want.count, n);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] value;
  logic                     cfg_we;
  logic [CAP_W-1:0]         cfg_wdata;
  logic                     done;
  logic signed [DATA_W-1:0] data;
  logic [ST_W-1:0]          status;
  logic [CAP_W-1:0]         count;

  queue_scoreboard sb = new();

  circular_queue_double_ended_pop uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .data      (data),
    .status    (status),
    .count     (count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_reply(data, status, count);
  end

  task automatic issue(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
    start <= 1'b1;
    command <= cmd;
    value <= val;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(cmd, val);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    start <= 1'b0;
    while (sb.replies_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.capacity = cap;
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int enq_pct);
    int r;
    logic [CMD_W-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < enq_pct) return CMD_ENQ;
    r = $urandom_range(0, 99);
    if (r < 30) cmd = CMD_DEQ_FRONT;
    else if (r < 55) cmd = CMD_DEQ_REAR;
    else if (r < 72) cmd = CMD_PEEK_FRONT;
    else if (r < 89) cmd = CMD_PEEK_REAR;
    else if (r < 95) cmd = CMD_CLEAR;
    else if (r < 97) cmd = CMD_UNUSED_A;
    else cmd = CMD_UNUSED_B;
    if (!sb.readable(cmd)) cmd = CMD_ENQ;
    return cmd;
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd64;
      4: return CAP_W'($urandom_range(65, 127));
      default: return CAP_W'($urandom_range(3, 63));
    endcase
  endfunction

  task automatic run_phase(int idle_pct, int beats);
    int enq_pct;
    enq_pct = $urandom_range(30, 85);
    for (int i = 0; i < beats; i++) begin
      if (i > 0 && $urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      issue(pick_command(enq_pct), pick_word());
    end
  endtask

  initial begin
    int idle_pct [3];
    int left;
    int n;
    int waited;
    idle_pct = '{34, 48, 0};
    rst = 1'b1;
    start = 1'b0;
    command = CMD_ENQ;
    value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, extreme words, all commands
    issue(CMD_PEEK_FRONT, '0);
    issue(CMD_PEEK_REAR, '1);
    issue(CMD_DEQ_FRONT, '0);
    issue(CMD_DEQ_REAR, '0);
    issue(CMD_ENQ, 32'h7fff_ffff);
    issue(CMD_ENQ, 32'h8000_0000);
    issue(CMD_ENQ, '0);
    issue(CMD_ENQ, '1);
    issue(CMD_PEEK_FRONT, '0);
    issue(CMD_PEEK_REAR, '0);
    issue(CMD_DEQ_REAR, '0);
    issue(CMD_DEQ_FRONT, '0);
    issue(CMD_UNUSED_A, $urandom);
    issue(CMD_UNUSED_B, $urandom);
    issue(CMD_CLEAR, '0);

    // capacity 0 behaves as 1
    write_capacity(7'd0);
    issue(CMD_ENQ, 32'ha5a5_a5a5);
    issue(CMD_ENQ, 32'h5a5a_5a5a);
    issue(CMD_DEQ_REAR, '0);

    // oversize capacity, then shrink below the stored count
    write_capacity(7'd127);
    for (int i = 0; i < 5; i++) issue(CMD_ENQ, $urandom);
    write_capacity(7'd3);
    issue(CMD_ENQ, $urandom);
    issue(CMD_DEQ_REAR, '0);
    issue(CMD_DEQ_FRONT, '0);
    issue(CMD_PEEK_REAR, '0);
    issue(CMD_CLEAR, '0);

    foreach (idle_pct[k]) begin
      left = BEATS_PER_REGIME;
      while (left > 0) begin
        write_capacity(pick_capacity());
        n = $urandom_range(20, 60);
        if (n > left) n = left;
        run_phase(idle_pct[k], n);
        left -= n;
      end
    end
    write_capacity(CAP_RESET);

    start <= 1'b0;
    waited = 0;
    while (sb.replies_q.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (sb.replies_q.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, sb.replies_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("circular_queue_double_ended_pop: match");
    end else begin
      $display("circular_queue_double_ended_pop: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("circular_queue_double_ended_pop: mismatch");
    $finish;
  end

endmodule
